[src/kpht_pkg.sv]
// ----------------------------------------------------------------------------
// kpht_pkg: key press / hold tracker shared types and codes
// Request and response item layouts, event codes and key status codes.
// ----------------------------------------------------------------------------
package kpht_pkg;

	// one incoming item
	typedef struct packed {
		logic [2:0]  func;
		logic [7:0]  key_code;
		logic [31:0] now;
	} kpht_req_t;

	// one result item
	typedef struct packed {
		logic [1:0]  key_state;
		logic [31:0] hold_time;
		logic        any_pressed;
		logic        any_held;
		logic        any_released;
	} kpht_rsp_t;

	// event codes; six and seven behave as a query
	localparam logic [2:0] FN_PRESS   = 3'd0;
	localparam logic [2:0] FN_RELEASE = 3'd1;
	localparam logic [2:0] FN_HOLD    = 3'd2;
	localparam logic [2:0] FN_TICK    = 3'd3;
	localparam logic [2:0] FN_QUERY   = 3'd4;
	localparam logic [2:0] FN_CLEAR   = 3'd5;

	// key status codes
	localparam logic [1:0] KS_NONE     = 2'd0;
	localparam logic [1:0] KS_PRESSED  = 2'd1;
	localparam logic [1:0] KS_HELD     = 2'd2;
	localparam logic [1:0] KS_RELEASED = 2'd3;

endpackage

[src/key_press_hold_tracker_unit.sv]
// ----------------------------------------------------------------------------
// key_press_hold_tracker_unit: per-key press / hold / release tracker
// Keeps status, press stamp and hold duration for every key code in one
// synchronous table and reports the addressed key plus summary flags.
// ----------------------------------------------------------------------------
// Usage: raise start with a request item while busy is low; the item is taken
// at that edge. Exactly one response item follows, shown on response for a
// single cycle with done high; the receiver cannot hold it off, so capture it
// on that cycle. Press, release, hold, query and unused codes hold busy
// high while the entry is updated: one table read, then modify and write
// back through the table's single write port, then the registered answer.
// A tick walks the whole table through the read-modify-write pipeline, one
// key a cycle, with busy high, and answers once the last entry is written
// back. A clear writes every entry back to none with busy high and answers
// once the last entry is written. With key_enable low an item answers on
// the next cycle, busy stays low, nothing changes and the answer is all
// zero. After reset a clearing pass runs with busy high before the first
// item is taken; configuration writes are taken at any time (cfg_ready is
// held high) but should only be made while busy is low. Key codes at or
// above KEY_COUNT leave the table alone and report none with zero duration,
// while the any_* flags are still reported.
// ----------------------------------------------------------------------------
module key_press_hold_tracker_unit #(
	parameter int KEY_COUNT = 256,
	parameter int TIME_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  kpht_pkg::kpht_req_t request,
	output logic                done,
	output kpht_pkg::kpht_rsp_t response,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data
);
	import kpht_pkg::*;

	localparam int KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
	localparam int CW = $clog2(KEY_COUNT + 1);

	typedef struct packed {
		logic [1:0]           status;
		logic [TIME_BITS-1:0] stamp;
		logic [TIME_BITS-1:0] hold;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_CLEAR  = 4'b0010,
		ST_UPDATE = 4'b0100,
		ST_TICK   = 4'b1000
	} state_t;

	state_t state_q;

	// key table: one read and one write port, read data registered
	entry_t mem [KEY_COUNT];
	entry_t rdata_q;
	logic [KW-1:0] raddr, waddr;
	entry_t wdata;
	logic we;

	// item registers
	logic [2:0]           func_q;
	logic [KW-1:0]        idx_q;
	logic                 vld_key_q;
	logic [TIME_BITS-1:0] now_q;
	logic                 key_enable_q;
	logic                 clr_report_q;

	// sweep pointer and tick pipeline stage
	logic [CW-1:0] ptr_q;
	logic          vld_s1;
	logic [KW-1:0] addr_s1;

	// tick capture of the addressed key
	logic [1:0]  cap_status_q;
	logic [31:0] cap_hold_q;

	logic [CW-1:0] pressed_cnt_q, held_cnt_q, released_cnt_q;
	logic [CW-1:0] pressed_nxt, held_nxt, released_nxt;

	logic      done_q;
	kpht_rsp_t rsp_q;

	// decode of the incoming key code and time
	logic [KW+7:0]           code_ext;
	logic [KW-1:0]           req_idx;
	logic                    req_vld;
	logic [TIME_BITS+31:0]   now_ext;
	logic                    accept;

	entry_t                cur, nxt;
	logic [TIME_BITS+31:0] hold_ext;
	logic [31:0]           nxt_hold32;

	assign code_ext = {{KW{1'b0}}, request.key_code};
	assign req_idx  = code_ext[KW-1:0];
	assign req_vld  = code_ext < (KW + 8)'(KEY_COUNT);
	assign now_ext  = {{TIME_BITS{1'b0}}, request.now};
	assign accept   = start && (state_q == ST_IDLE);

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign response  = rsp_q;

	// read address: the addressed key when an item is taken, else the sweep
	always_comb begin
		if (state_q == ST_TICK) begin
			raddr = ptr_q[KW-1:0];
		end else begin
			raddr = req_idx;
		end
	end

	// modify the entry that was read
	always_comb begin
		cur = rdata_q;
		nxt = cur;
		if (state_q == ST_TICK) begin
			case (cur.status)
				KS_RELEASED: begin
					nxt.status = KS_NONE;
					nxt.hold   = '0;
				end
				KS_HELD: begin
					if (cur.stamp != '0) begin
						nxt.hold = now_q - cur.stamp;
					end else begin
						nxt.hold  = '0;
						nxt.stamp = now_q;
					end
				end
				KS_PRESSED: begin
					nxt.hold = '0;
				end
				default: begin
				end
			endcase
		end else if (vld_key_q) begin
			case (func_q)
				// a press on a down key behaves as a hold
				FN_PRESS, FN_HOLD: begin
					if (cur.status == KS_PRESSED || cur.status == KS_HELD) begin
						nxt.status = KS_HELD;
						if (cur.stamp != '0) begin
							nxt.hold = now_q - cur.stamp;
						end else begin
							nxt.hold  = '0;
							nxt.stamp = now_q;
						end
					end else begin
						nxt.status = KS_PRESSED;
						nxt.stamp  = now_q;
					end
				end
				FN_RELEASE: begin
					nxt.status = KS_RELEASED;
					nxt.stamp  = '0;
				end
				default: begin
				end
			endcase
		end
	end

	assign hold_ext   = {32'd0, nxt.hold};
	assign nxt_hold32 = hold_ext[31:0];

	// status counts follow the entry being written back
	assign pressed_nxt  = pressed_cnt_q + CW'(nxt.status == KS_PRESSED)
		- CW'(cur.status == KS_PRESSED);
	assign held_nxt     = held_cnt_q + CW'(nxt.status == KS_HELD)
		- CW'(cur.status == KS_HELD);
	assign released_nxt = released_cnt_q + CW'(nxt.status == KS_RELEASED)
		- CW'(cur.status == KS_RELEASED);

	// write port: zero fill during a clear, write back otherwise
	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = nxt;
		case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = ptr_q[KW-1:0];
				wdata = '0;
			end
			ST_TICK: begin
				we    = vld_s1;
				waddr = addr_s1;
			end
			ST_UPDATE: begin
				we = vld_key_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_enable_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			key_enable_q <= cfg_data;
		end
	end

	// sequencer, counts and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			ptr_q          <= '0;
			vld_s1         <= 1'b0;
			clr_report_q   <= 1'b0;
			pressed_cnt_q  <= '0;
			held_cnt_q     <= '0;
			released_cnt_q <= '0;
			done_q         <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!key_enable_q) begin
							// disabled: answer zero, leave the table alone
							done_q <= 1'b1;
							rsp_q  <= '0;
						end else if (request.func == FN_CLEAR) begin
							ptr_q        <= '0;
							clr_report_q <= 1'b1;
							state_q      <= ST_CLEAR;
						end else if (request.func == FN_TICK) begin
							ptr_q        <= '0;
							vld_s1       <= 1'b0;
							cap_status_q <= KS_NONE;
							cap_hold_q   <= '0;
							state_q      <= ST_TICK;
						end else begin
							state_q <= ST_UPDATE;
						end
						func_q    <= request.func;
						idx_q     <= req_idx;
						vld_key_q <= req_vld;
						now_q     <= now_ext[TIME_BITS-1:0];
					end
				end
				ST_CLEAR: begin
					pressed_cnt_q  <= '0;
					held_cnt_q     <= '0;
					released_cnt_q <= '0;
					ptr_q          <= ptr_q + CW'(1);
					if (ptr_q == CW'(KEY_COUNT - 1)) begin
						state_q      <= ST_IDLE;
						done_q       <= clr_report_q;
						rsp_q        <= '0;
						clr_report_q <= 1'b0;
					end
				end
				ST_UPDATE: begin
					pressed_cnt_q   <= pressed_nxt;
					held_cnt_q      <= held_nxt;
					released_cnt_q  <= released_nxt;
					done_q          <= 1'b1;
					rsp_q.key_state <= vld_key_q ? nxt.status : KS_NONE;
					rsp_q.hold_time <= (vld_key_q && nxt.status == KS_HELD) ?
						nxt_hold32 : 32'd0;
					rsp_q.any_pressed  <= (pressed_nxt != '0);
					rsp_q.any_held     <= (held_nxt != '0);
					rsp_q.any_released <= (released_nxt != '0);
					state_q         <= ST_IDLE;
				end
				ST_TICK: begin
					// issue the next read while the previous entry is written back
					if (ptr_q != CW'(KEY_COUNT)) begin
						ptr_q   <= ptr_q + CW'(1);
						vld_s1  <= 1'b1;
						addr_s1 <= ptr_q[KW-1:0];
					end else begin
						vld_s1 <= 1'b0;
					end
					if (vld_s1) begin
						pressed_cnt_q  <= pressed_nxt;
						held_cnt_q     <= held_nxt;
						released_cnt_q <= released_nxt;
						if (vld_key_q && addr_s1 == idx_q) begin
							cap_status_q <= nxt.status;
							cap_hold_q   <= (nxt.status == KS_HELD) ? nxt_hold32 : 32'd0;
						end
					end
					if (ptr_q == CW'(KEY_COUNT) && !vld_s1) begin
						done_q             <= 1'b1;
						rsp_q.key_state    <= cap_status_q;
						rsp_q.hold_time    <= cap_hold_q;
						rsp_q.any_pressed  <= (pressed_cnt_q != '0);
						rsp_q.any_held     <= (held_cnt_q != '0);
						rsp_q.any_released <= (released_cnt_q != '0);
						state_q            <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// the table is only written by a running item or a clearing pass
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q != ST_IDLE))
		else $error("table written while idle");

	// the keys counted never outnumber the table
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((CW + 2)'(pressed_cnt_q) + (CW + 2)'(held_cnt_q) + (CW + 2)'(released_cnt_q))
			<= (CW + 2)'(KEY_COUNT))
		else $error("status counts exceed key count");

	// a clearing pass leaves every count at zero
	a_clear_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |=>
			(pressed_cnt_q == '0 && held_cnt_q == '0 && released_cnt_q == '0))
		else $error("counts not cleared");

	// a duration is only reported for a held key
	a_hold_only_held: assert property (@(posedge clk) disable iff (!arst_n)
		(done && response.hold_time != 32'd0) |-> (response.key_state == KS_HELD))
		else $error("hold time reported for a key that is not held");

	// the tick write-back stage runs only inside a tick sweep
	a_tick_stage: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == ST_TICK))
		else $error("tick stage valid outside a sweep");

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: regression bench for key_press_hold_tracker_unit
// Drives press, release, hold, tick, query and clear items through the start
// and busy handshake. A behavioural copy of the key table in this file
// predicts every result item. A checker compares each strobed result with the
// oldest pending prediction, field by field. Directed sequences come first,
// then enable register toggling, then long runs of random key traffic with
// and without sender idling.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import kpht_pkg::*;

	localparam int KEYS = 256;

	// DUT ports; every input has a known value from time zero
	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      start     = 1'b0;
	logic      busy;
	kpht_req_t request   = '0;
	logic      done;
	kpht_rsp_t response;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic      cfg_data  = 1'b0;

	// behavioural copy of the key table and of the enable register
	logic [1:0]  key_status  [KEYS];
	logic [31:0] press_stamp [KEYS];
	logic [31:0] hold_span   [KEYS];
	logic        key_en;

	// predicted result items, oldest first
	kpht_rsp_t pending_rsp[$];

	int fail_count = 0;
	// chance in a hundred that the sender idles on a given cycle
	int idle_pct = 36;

	key_press_hold_tracker_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.done      (done),
		.response  (response),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// key table prediction
	// ------------------------------------------------------------------------

	// drop every key back to none with zero stamp and duration
	function automatic void wipe_tables();
		int i;
		for (i = 0; i < KEYS; i++) begin
			key_status[i]  = KS_NONE;
			press_stamp[i] = '0;
			hold_span[i]   = '0;
		end
	endfunction

	// refresh the duration of a held key; a zero stamp restarts the stamp
	// instead, so a key first pressed at time zero reads a duration of zero
	function automatic void refresh_span(int k, logic [31:0] t);
		if (press_stamp[k] != '0) begin
			hold_span[k] = t - press_stamp[k];
		end else begin
			hold_span[k]   = '0;
			press_stamp[k] = t;
		end
	endfunction

	// press and hold behave alike: a fresh key becomes pressed and takes the
	// stamp, a pressed or held key becomes held with a refreshed duration
	function automatic void press_or_hold(int k, logic [31:0] t);
		if (key_status[k] == KS_NONE || key_status[k] == KS_RELEASED) begin
			key_status[k]  = KS_PRESSED;
			press_stamp[k] = t;
		end else begin
			key_status[k] = KS_HELD;
			refresh_span(k, t);
		end
	endfunction

	// advance the key table by one item and return the result it must give
	function automatic kpht_rsp_t apply_event(kpht_req_t it);
		kpht_rsp_t r;
		int        k;
		int        i;
		r = '0;
		k = int'(it.key_code);
		// a disabled block changes nothing and answers all zero
		if (!key_en)
			return r;
		case (it.func)
			FN_CLEAR: wipe_tables();
			FN_TICK: begin
				for (i = 0; i < KEYS; i++) begin
					case (key_status[i])
						KS_RELEASED: begin
							key_status[i] = KS_NONE;
							hold_span[i]  = '0;
						end
						KS_HELD:    refresh_span(i, it.now);
						KS_PRESSED: hold_span[i] = '0;
						default: ;
					endcase
				end
			end
			FN_PRESS, FN_HOLD: press_or_hold(k, it.now);
			FN_RELEASE: begin
				// the duration survives a release; only the stamp is dropped
				key_status[k]  = KS_RELEASED;
				press_stamp[k] = '0;
			end
			// query and the two unused codes leave the table alone
			default: ;
		endcase
		r.key_state = key_status[k];
		r.hold_time = (key_status[k] == KS_HELD) ? hold_span[k] : '0;
		for (i = 0; i < KEYS; i++) begin
			if (key_status[i] == KS_PRESSED)  r.any_pressed  = 1'b1;
			if (key_status[i] == KS_HELD)     r.any_held     = 1'b1;
			if (key_status[i] == KS_RELEASED) r.any_released = 1'b1;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------------

	function automatic void match_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	// a result sits on the ports for exactly one cycle: take it at the edge
	// that ends that cycle and hold it against the oldest prediction
	always @(posedge clk) begin : check_result
		kpht_rsp_t want;
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				$error("result item with no prediction pending: 0x%0h", response);
				fail_count++;
			end else begin
				want = pending_rsp.pop_front();
				match_field("key_state", 32'(want.key_state), 32'(response.key_state));
				match_field("hold_time", want.hold_time, response.hold_time);
				match_field("any_pressed", 32'(want.any_pressed),
					32'(response.any_pressed));
				match_field("any_held", 32'(want.any_held), 32'(response.any_held));
				match_field("any_released", 32'(want.any_released),
					32'(response.any_released));
			end
		end
	end

	// ------------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------------

	// Offer one item and hold it until the block takes it. Called on a rising
	// edge. start is left high on return so that back-to-back items never
	// lower and raise it within one time step; idling lowers it instead.
	task automatic send_event(logic [2:0] fn, logic [7:0] key, logic [31:0] t);
		kpht_req_t it;
		int        gap;
		it.func     = fn;
		it.key_code = key;
		it.now      = t;
		gap = 0;
		if (idle_pct != 0) begin
			while ($urandom_range(99) < idle_pct)
				gap++;
			// now and then a long pause, so gaps also cover a whole table walk
			if ($urandom_range(199) == 0)
				gap += $urandom_range(300);
		end
		repeat (gap) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start   <= 1'b1;
		request <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		// taken at this edge: predict now, before any later item can land
		pending_rsp.push_back(apply_event(it));
	endtask

	// lower start and wait until every predicted result has come back
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() != 0 || busy)
			@(posedge clk);
	endtask

	// write the enable register; only ever called with the block idle
	task automatic write_enable(logic v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		key_en = v;
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// single-key transitions, field extremes, wrap of the timer, unused codes
	task automatic test_press_hold_release();
		// pressed at time zero: the first hold restarts the stamp
		send_event(FN_PRESS, 8'd0, 32'd0);
		send_event(FN_HOLD, 8'd0, 32'd100);
		// press on a held key acts as a hold: duration 250
		send_event(FN_PRESS, 8'd0, 32'd350);
		// top key, top time, then a hold after the timer wraps
		send_event(FN_PRESS, 8'd255, 32'hFFFF_FFFF);
		send_event(FN_HOLD, 8'd255, 32'h0000_0010);
		send_event(FN_QUERY, 8'd255, 32'd0);
		// release reads zero duration and drops the stamp
		send_event(FN_RELEASE, 8'd255, 32'hAAAA_AAAA);
		// hold on a released key restarts it as pressed
		send_event(FN_HOLD, 8'd255, 32'h5555_5555);
		// release of a key never pressed, hold of a key never pressed
		send_event(FN_RELEASE, 8'h5A, 32'd1);
		send_event(FN_HOLD, 8'hA5, 32'd7);
		// unused codes behave as queries
		send_event(3'd6, 8'd0, 32'd0);
		send_event(3'd7, 8'd255, 32'hFFFF_FFFF);
	endtask

	// table walks: ticks over every status, zero stamps in a tick, clear
	task automatic test_tick_and_clear();
		// held with stamp 100 gets 900, pressed keys clear, released go to none
		send_event(FN_TICK, 8'd0, 32'd1000);
		send_event(FN_QUERY, 8'h5A, 32'd0);
		// key pressed twice at time zero: held with a zero stamp
		send_event(FN_PRESS, 8'd3, 32'd0);
		send_event(FN_PRESS, 8'd3, 32'd0);
		// first tick restarts the stamp at 50, the second gives 30
		send_event(FN_TICK, 8'd3, 32'd50);
		send_event(FN_TICK, 8'd3, 32'd80);
		send_event(FN_RELEASE, 8'd0, 32'd90);
		send_event(FN_TICK, 8'd0, 32'hFFFF_FFFF);
		send_event(FN_CLEAR, 8'd3, 32'd0);
		send_event(FN_QUERY, 8'd255, 32'd0);
		send_event(FN_TICK, 8'd0, 32'd5);
	endtask

	// with the enable clear nothing moves, clear included, and results are zero
	task automatic test_enable_register(int n_off);
		// leave a held key behind so the frozen state can be seen afterwards
		send_event(FN_PRESS, 8'd3, 32'd10);
		send_event(FN_PRESS, 8'd3, 32'd40);
		send_event(FN_PRESS, 8'd200, 32'd45);
		wait_drained();
		write_enable(1'b0);
		send_event(FN_CLEAR, 8'd3, 32'd0);
		send_event(FN_TICK, 8'd3, 32'hFFFF_FFFF);
		send_event(FN_RELEASE, 8'd3, 32'd60);
		send_event(FN_QUERY, 8'd200, 32'd0);
		repeat (n_off)
			send_event(3'($urandom_range(7)), 8'($urandom_range(255)), $urandom);
		wait_drained();
		write_enable(1'b1);
		send_event(FN_QUERY, 8'd3, 32'd0);
		send_event(FN_QUERY, 8'd200, 32'd0);
	endtask

	// random traffic on a few busy keys, with some spread over all codes
	task automatic test_random_traffic(int count, int idle);
		logic [7:0]  pool [4];
		logic [2:0]  fn;
		logic [7:0]  key;
		logic [31:0] wall;
		logic [31:0] t;
		int          pick;
		int          n;
		idle_pct = idle;
		wall     = $urandom_range(1000);
		for (n = 0; n < count; n++) begin
			// refresh the key pool now and then; keep both end codes in it
			if (n % 200 == 0) begin
				pool[0] = 8'd0;
				pool[1] = 8'd255;
				pool[2] = 8'($urandom_range(255));
				pool[3] = 8'($urandom_range(255));
			end
			pick = $urandom_range(99);
			if (pick < 28)      fn = FN_PRESS;
			else if (pick < 52) fn = FN_HOLD;
			else if (pick < 68) fn = FN_RELEASE;
			else if (pick < 83) fn = FN_QUERY;
			else if (pick < 94) fn = FN_TICK;
			else if (pick < 98) fn = 3'($urandom_range(6, 7));
			else                fn = FN_CLEAR;
			key = ($urandom_range(99) < 80) ? pool[$urandom_range(3)]
			                                : 8'($urandom_range(255));
			// time mostly runs forward; sometimes jump, wrap or read zero
			wall += $urandom_range(1, 2000);
			pick = $urandom_range(99);
			if (pick < 3)      wall = $urandom;
			else if (pick < 5) wall = 32'hFFFF_FFFF - $urandom_range(3000);
			pick = $urandom_range(99);
			if (pick < 3)      t = '0;
			else if (pick < 6) t = $urandom;
			else               t = wall;
			send_event(fn, key, t);
		end
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------

	initial begin
		wipe_tables();
		key_en = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		// the block runs its clearing pass first; send_event waits on busy
		test_press_hold_release();
		test_tick_and_clear();
		test_enable_register(40);
		test_random_traffic(700, 36);
		// long stretch with the sender never idling
		test_random_traffic(500, 0);
		idle_pct = 36;
		test_enable_register(20);
		test_random_traffic(500, 36);
		wait_drained();
		// hold a table walk's worth of cycles to catch any stray result
		repeat (KEYS + 8) @(posedge clk);
		if (fail_count == 0)
			$display("key_press_hold_tracker_unit regression: pass");
		else
			$display("key_press_hold_tracker_unit regression: fail");
		$finish;
	end

	// watchdog: several times the slowest correct run
	initial begin
		#20ms;
		$display("key_press_hold_tracker_unit regression: fail");
		$finish;
	end

endmodule

[files.f]
src/kpht_pkg.sv
src/key_press_hold_tracker_unit.sv
dv/tb_top.sv
